// ===== sv/binary_to_decimal_ascii_formatter_core_assert.svh =====
// Assertion macros for the formatter core.
// Clock and reset names are fixed to the core's ports.
`ifndef BINARY_TO_DECIMAL_ASCII_FORMATTER_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_FORMATTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define B2D_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define B2D_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define B2D_ASSERT_IMPLIES(label, ante, cons)
`define B2D_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/b2d_pkg.sv =====
package b2d_pkg;

   localparam int unsigned MAX_DIGITS  = 10;
   localparam int unsigned FRAC_DIGITS = 3;

   typedef logic [3:0] cnt_type;
   typedef logic [3:0] digit_type;

   typedef enum logic [1:0] {
      FMT_UNSIGNED = 2'd0,
      FMT_SIGNED   = 2'd1,
      FMT_FIXED    = 2'd2,
      FMT_UNUSED   = 2'd3
   } fmt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   // Exact x/10 for any 32-bit x: (x * 0xCCCCCCCD) >> 35
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int unsigned DIV10_SHIFT = 35;

   localparam cnt_type MIN_DIGITS_INT   = 4'd1;
   localparam cnt_type MIN_DIGITS_FIXED = 4'd4;
   localparam cnt_type LAST_DIGIT_CNT   = 4'(MAX_DIGITS);
   localparam cnt_type DOT_PTR          = 4'(FRAC_DIGITS - 1);

   typedef struct packed {
      logic [31:0] quotient;
      digit_type   digit;
   } div_result_type;

endpackage

// ===== sv/b2d_req_if.sv =====
interface b2d_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] value_bits;

   modport source (output valid, output req_type, output value_bits, input ready);
   modport sink   (input valid, input req_type, input value_bits, output ready);
endinterface

// ===== sv/b2d_rsp_if.sv =====
interface b2d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/b2d_div10.sv =====
// Shared divide-by-ten unit: quotient and remainder digit.
module b2d_div10 (
   input  logic [31:0]             dividend,
   output b2d_pkg::div_result_type result
);
   logic [63:0] product;
   logic [31:0] quot;
   logic [31:0] quot_x10;
   logic [31:0] rem;

   assign product  = {32'd0, dividend} * {32'd0, b2d_pkg::DIV10_RECIP};
   assign quot     = 32'(product[63:b2d_pkg::DIV10_SHIFT]);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = dividend - quot_x10;

   assign result.quotient = quot;
   assign result.digit    = rem[3:0];
endmodule

// ===== sv/binary_to_decimal_ascii_formatter_core.sv =====
// An accepted value is converted into D digits, then its C characters are emitted,
//   D = digits converted (1..10; at least 4 in fixed-point mode),
//   C = characters emitted (1..12). The divide-by-ten unit yields one digit per cycle,
//   then one character per cycle unless the output stalls; a new value waits for idle.
// Selector 3 is accepted and dropped with no characters.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
`include "binary_to_decimal_ascii_formatter_core_assert.svh"

module binary_to_decimal_ascii_formatter_core (
   input  logic      clock,
   input  logic      reset,
   b2d_req_if.sink   req_if,
   b2d_rsp_if.source rsp_if
);

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   b2d_pkg::state_type state_ff, state_in;

   b2d_pkg::fmt_type   mode_ff, mode_in;
   logic               neg_ff, neg_in;
   logic [31:0]        work_ff, work_in;     // remaining magnitude
   b2d_pkg::cnt_type   cnt_ff, cnt_in;       // digits converted so far
   b2d_pkg::cnt_type   ptr_ff, ptr_in;       // next digit to emit
   logic               sign_ff, sign_in;     // '-' still to send
   logic               dot_ff, dot_in;       // '.' still to send
   b2d_pkg::digit_type digit_ff [b2d_pkg::MAX_DIGITS];

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;

   // ---------------------------------------------------------------
   // Shared divide unit works on the remaining magnitude
   // ---------------------------------------------------------------
   b2d_pkg::div_result_type div_res;

   b2d_div10 u_div10 (
      .dividend (work_ff),
      .result   (div_res)
   );

   // ---------------------------------------------------------------
   // Decode
   // ---------------------------------------------------------------
   logic               req_fire;
   logic               slot_free;
   logic               load;
   logic               emit_dot;
   logic               conv_done;
   b2d_pkg::cnt_type   cnt_next;
   b2d_pkg::cnt_type   min_digits;
   b2d_pkg::fmt_type   req_fmt;
   logic               req_neg;

   assign req_fmt   = b2d_pkg::fmt_type'(req_if.req_type);
   assign req_fire  = req_if.valid && req_if.ready;
   assign req_neg   = (req_fmt != b2d_pkg::FMT_UNSIGNED) && req_if.value_bits[31];
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign load      = (state_ff == b2d_pkg::ST_EMIT) && slot_free;
   assign emit_dot  = !sign_ff && dot_ff && (ptr_ff == b2d_pkg::DOT_PTR);

   assign cnt_next   = cnt_ff + 4'd1;
   assign min_digits = (mode_ff == b2d_pkg::FMT_FIXED) ? b2d_pkg::MIN_DIGITS_FIXED
                                                       : b2d_pkg::MIN_DIGITS_INT;
   assign conv_done  = ((div_res.quotient == 32'd0) && (cnt_next >= min_digits)) ||
                       (cnt_next == b2d_pkg::LAST_DIGIT_CNT);

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         b2d_pkg::ST_IDLE: begin
            if (req_fire && (req_fmt != b2d_pkg::FMT_UNUSED)) begin
               state_in = b2d_pkg::ST_CONV;
            end
         end
         b2d_pkg::ST_CONV: begin
            if (conv_done) begin
               state_in = b2d_pkg::ST_EMIT;
            end
         end
         b2d_pkg::ST_EMIT: begin
            // final digit leaves: back to idle
            if (load && !sign_ff && !emit_dot && (ptr_ff == 4'd0)) begin
               state_in = b2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = b2d_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Outputs and datapath
   // ---------------------------------------------------------------
   assign req_if.ready = (state_ff == b2d_pkg::ST_IDLE);

   always_comb begin
      mode_in      = mode_ff;
      neg_in       = neg_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      sign_in      = sign_ff;
      dot_in       = dot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         b2d_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_in = req_fmt;
               neg_in  = req_neg;
               work_in = req_neg ? (32'd0 - req_if.value_bits) : req_if.value_bits;
               cnt_in  = 4'd0;
            end
         end
         b2d_pkg::ST_CONV: begin
            work_in = div_res.quotient;
            cnt_in  = cnt_next;
            if (conv_done) begin
               ptr_in  = cnt_ff;
               sign_in = neg_ff;
               dot_in  = (mode_ff == b2d_pkg::FMT_FIXED);
            end
         end
         b2d_pkg::ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               if (sign_ff) begin
                  char_in = b2d_pkg::CHAR_MINUS;
                  sign_in = 1'b0;
               end else if (emit_dot) begin
                  char_in = b2d_pkg::CHAR_DOT;
                  dot_in  = 1'b0;
               end else begin
                  char_in = b2d_pkg::CHAR_ZERO + {4'd0, digit_ff[ptr_ff]};
                  last_in = (ptr_ff == 4'd0);
                  ptr_in  = ptr_ff - 4'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = char_ff;
   assign rsp_if.last_char = last_ff;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b2d_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         dot_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sign_ff      <= sign_in;
         dot_ff       <= dot_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      neg_ff  <= neg_in;
      work_ff <= work_in;
      cnt_ff  <= cnt_in;
      ptr_ff  <= ptr_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (state_ff == b2d_pkg::ST_CONV) begin
         digit_ff[cnt_ff] <= div_res.digit;
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `B2D_ASSERT_NEXT(a_unused_fmt_dropped, req_fire && (req_fmt == b2d_pkg::FMT_UNUSED), state_ff == b2d_pkg::ST_IDLE)
   `B2D_ASSERT_IMPLIES(a_dot_only_fixed, (state_ff == b2d_pkg::ST_EMIT) && dot_ff, (mode_ff == b2d_pkg::FMT_FIXED) && (ptr_ff >= b2d_pkg::DOT_PTR))
   `B2D_ASSERT_IMPLIES(a_conv_count_bound, state_ff == b2d_pkg::ST_CONV, cnt_ff < b2d_pkg::LAST_DIGIT_CNT)
   `B2D_ASSERT_NEXT(a_last_ends_emit, load && !sign_ff && !emit_dot && (ptr_ff == 4'd0), (state_ff == b2d_pkg::ST_IDLE) && rsp_valid_ff && last_ff)

endmodule
